/* design/bpt_pkg.sv */
// Shared types and constants of the barometric compensation pipeline.
package bpt_pkg;

	// Pipeline depth from input register to output register.
	localparam int NUM_STAGES = 9;

	// Field and intermediate widths.
	localparam int CAL_W   = 16;
	localparam int D_W     = 24;
	localparam int DT_W    = 25;
	localparam int PROD_W  = 42;
	localparam int SQ_W    = 48;
	localparam int X_W     = 19;
	localparam int TEMP_W  = 21;
	localparam int WIDE_W  = 41;
	localparam int A_W     = 35;
	localparam int B_W     = 36;
	localparam int PRESS_W = 20;
	localparam int TOUT_W  = 16;
	localparam int IDX_W   = 3;

	// Calibration register indexes.
	localparam logic [IDX_W-1:0] REG_C1 = 3'd0;
	localparam logic [IDX_W-1:0] REG_C2 = 3'd1;
	localparam logic [IDX_W-1:0] REG_C3 = 3'd2;
	localparam logic [IDX_W-1:0] REG_C4 = 3'd3;
	localparam logic [IDX_W-1:0] REG_C5 = 3'd4;
	localparam logic [IDX_W-1:0] REG_C6 = 3'd5;

	// Reference temperature of 20.00 C, and its distance to -15.00 C.
	localparam logic signed [TEMP_W-1:0] TEMP_REF        = 21'sd2000;
	localparam logic signed [X_W:0]      LOW_TEMP_OFFSET = 20'sd3500;

	// Saturation limits of the results.
	localparam logic [PRESS_W-1:0]        PRESS_MAX = 20'hFFFFF;
	localparam logic signed [TOUT_W-1:0]  TEMP_MAX  = 16'sh7FFF;
	localparam logic signed [TOUT_W-1:0]  TEMP_MIN  = 16'sh8000;

	// Calibration words C1 to C6.
	typedef struct packed {
		logic [CAL_W-1:0] c1;
		logic [CAL_W-1:0] c2;
		logic [CAL_W-1:0] c3;
		logic [CAL_W-1:0] c4;
		logic [CAL_W-1:0] c5;
		logic [CAL_W-1:0] c6;
	} bpt_cal_t;

	// Item state after the temperature stages.
	typedef struct packed {
		logic [D_W-1:0]           d1;
		logic signed [TEMP_W-1:0] temp;
		logic signed [WIDE_W-1:0] off1;
		logic signed [WIDE_W-1:0] sens1;
		logic [A_W-1:0]           a;
		logic [B_W-1:0]           b;
		logic                     lt2000;
		logic                     lt1500;
	} bpt_s4_t;

endpackage

/* design/bpt_cal_regs.sv */
// Calibration register file written through the configuration port.
module bpt_cal_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bpt_pkg::IDX_W-1:0]     cfg_index,
	input  logic [bpt_pkg::CAL_W-1:0]     cfg_data,
	output bpt_pkg::bpt_cal_t             cal
);

	bpt_pkg::bpt_cal_t cal_q;

	// Write one calibration word; indexes beyond C6 are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				bpt_pkg::REG_C1: begin
					cal_q.c1 <= cfg_data;
				end
				bpt_pkg::REG_C2: begin
					cal_q.c2 <= cfg_data;
				end
				bpt_pkg::REG_C3: begin
					cal_q.c3 <= cfg_data;
				end
				bpt_pkg::REG_C4: begin
					cal_q.c4 <= cfg_data;
				end
				bpt_pkg::REG_C5: begin
					cal_q.c5 <= cfg_data;
				end
				bpt_pkg::REG_C6: begin
					cal_q.c6 <= cfg_data;
				end
				default: begin
					cal_q <= cal_q;
				end
			endcase
		end
	end

	assign cal = cal_q;

endmodule

/* design/bpt_pipe_ctrl.sv */
// Valid bits and per-stage load enables of the compensation pipeline.
module bpt_pipe_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           out_ready,
	output logic [bpt_pkg::NUM_STAGES:1]   en,
	output logic                           out_valid
);

	logic [bpt_pkg::NUM_STAGES:1] valid_q;

	// A stage loads when it is empty or when the stage after it moves on.
	always_comb begin
		en[bpt_pkg::NUM_STAGES] = !valid_q[bpt_pkg::NUM_STAGES] || out_ready;
		for (int k = bpt_pkg::NUM_STAGES - 1; k >= 1; k--) begin
			en[k] = !valid_q[k] || en[k+1];
		end
	end

	// Valid bits travel with the items.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (en[1]) begin
				valid_q[1] <= in_valid;
			end
			for (int k = 2; k <= bpt_pkg::NUM_STAGES; k++) begin
				if (en[k]) begin
					valid_q[k] <= valid_q[k-1];
				end
			end
		end
	end

	assign out_valid = valid_q[bpt_pkg::NUM_STAGES];

`ifndef NO_ASSERTIONS
	// Input back-pressure only when every stage holds an item.
	assert property (@(posedge clk) disable iff (!arst_n)
		!en[1] |-> (&valid_q))
		else $error("input stalled while the pipeline has a bubble");

	// An accepted item lands in the first stage.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && en[1]) |=> valid_q[1])
		else $error("accepted item lost at the first stage");

	// A stall at stage two freezes every later stage.
	assert property (@(posedge clk) disable iff (!arst_n)
		!en[2] |=> $stable(valid_q[bpt_pkg::NUM_STAGES:2]))
		else $error("downstream valid bits moved during a stall");
`endif

endmodule

/* design/bpt_temp_stages.sv */
// Stages one to four: dT, first-order terms and the correction squares.
module bpt_temp_stages (
	input  logic                      clk,
	input  logic [4:1]                en,
	input  bpt_pkg::bpt_cal_t         cal,
	input  logic [bpt_pkg::D_W-1:0]   raw_pressure,
	input  logic [bpt_pkg::D_W-1:0]   raw_temperature,
	output bpt_pkg::bpt_s4_t          s4
);

	logic [bpt_pkg::D_W-1:0]            d1_s1, d1_s2, d1_s3;
	logic signed [bpt_pkg::DT_W-1:0]    dt_s1;
	logic signed [bpt_pkg::PROD_W-1:0]  p6_s2, p4_s2, p3_s2;
	logic [bpt_pkg::SQ_W-1:0]           pdd_s2;
	logic signed [bpt_pkg::X_W-1:0]     x_s3;
	logic signed [bpt_pkg::X_W:0]       y_s3;
	logic [16:0]                        t2_s3;
	logic signed [bpt_pkg::WIDE_W-1:0]  off1_s3, sens1_s3;
	bpt_pkg::bpt_s4_t                   stage_s4;

	logic signed [2*bpt_pkg::DT_W-1:0]  dt_sq;
	logic signed [bpt_pkg::X_W-1:0]     x_c;
	logic signed [bpt_pkg::WIDE_W-1:0]  off1_c, sens1_c;
	logic signed [2*bpt_pkg::X_W-1:0]   a_full;
	logic signed [2*bpt_pkg::X_W+1:0]   b_full;
	logic [bpt_pkg::TEMP_W-1:0]         t2_sel;

	// Stage 1: dT = D2 - C5 * 256.
	always_ff @(posedge clk) begin
		if (en[1]) begin
			d1_s1 <= raw_pressure;
			dt_s1 <= $signed({1'b0, raw_temperature}) - $signed({1'b0, cal.c5, 8'h00});
		end
	end

	// Stage 2: the four products of dT.
	assign dt_sq = dt_s1 * dt_s1;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			d1_s2  <= d1_s1;
			p6_s2  <= dt_s1 * $signed({1'b0, cal.c6});
			p4_s2  <= dt_s1 * $signed({1'b0, cal.c4});
			p3_s2  <= dt_s1 * $signed({1'b0, cal.c3});
			pdd_s2 <= dt_sq[bpt_pkg::SQ_W-1:0];
		end
	end

	// Stage 3: first-order TEMP offset, OFF and SENS; T2 = dT^2 / 2^31.
	assign x_c     = $signed(p6_s2[41:23]);
	assign off1_c  = $signed({{6{p4_s2[41]}}, p4_s2[41:7]})
		+ $signed({9'b0, cal.c2, 16'b0});
	assign sens1_c = $signed({{7{p3_s2[41]}}, p3_s2[41:8]})
		+ $signed({10'b0, cal.c1, 15'b0});

	always_ff @(posedge clk) begin
		if (en[3]) begin
			d1_s3    <= d1_s2;
			x_s3     <= x_c;
			y_s3     <= $signed({x_c[bpt_pkg::X_W-1], x_c}) + bpt_pkg::LOW_TEMP_OFFSET;
			t2_s3    <= pdd_s2[47:31];
			off1_s3  <= off1_c;
			sens1_s3 <= sens1_c;
		end
	end

	// Stage 4: squares of the distances below 20 C and below -15 C.
	assign a_full = x_s3 * x_s3;
	assign b_full = y_s3 * y_s3;
	assign t2_sel = x_s3[bpt_pkg::X_W-1] ? {4'b0, t2_s3} : '0;

	always_ff @(posedge clk) begin
		if (en[4]) begin
			stage_s4.d1     <= d1_s3;
			stage_s4.temp   <= $signed({{2{x_s3[bpt_pkg::X_W-1]}}, x_s3})
				+ bpt_pkg::TEMP_REF - $signed(t2_sel);
			stage_s4.off1   <= off1_s3;
			stage_s4.sens1  <= sens1_s3;
			stage_s4.a      <= a_full[bpt_pkg::A_W-1:0];
			stage_s4.b      <= b_full[bpt_pkg::B_W-1:0];
			stage_s4.lt2000 <= x_s3[bpt_pkg::X_W-1];
			stage_s4.lt1500 <= y_s3[bpt_pkg::X_W];
		end
	end

	assign s4 = stage_s4;

endmodule

/* design/bpt_press_stages.sv */
// Stages five to nine: second-order terms, pressure product and saturation.
module bpt_press_stages (
	input  logic                                clk,
	input  logic [9:5]                          en,
	input  bpt_pkg::bpt_s4_t                    s4,
	output logic [bpt_pkg::PRESS_W-1:0]         pressure_pa,
	output logic signed [bpt_pkg::TOUT_W-1:0]   temperature_centi
);

	logic [bpt_pkg::D_W-1:0]             d1_s5, d1_s6;
	logic signed [bpt_pkg::TEMP_W-1:0]   temp_s5, temp_s6, temp_s7, temp_s8;
	logic signed [bpt_pkg::WIDE_W-1:0]   off1_s5, sens1_s5;
	logic [bpt_pkg::WIDE_W-1:0]          off2_s5, sens2_s5;
	logic signed [bpt_pkg::WIDE_W-1:0]   off_s6, sens_s6, off_s7, off_s8;
	logic [43:0]                         pp_lo_s7;
	logic signed [45:0]                  pp_hi_s7;
	logic signed [44:0]                  q_s8;
	logic [bpt_pkg::PRESS_W-1:0]         pressure_s9;
	logic signed [bpt_pkg::TOUT_W-1:0]   temperature_s9;

	logic [bpt_pkg::WIDE_W-1:0]  ext_a, ext_b, five_a, seven_b, eleven_b;
	logic [bpt_pkg::WIDE_W-1:0]  off2_c, sens2_c;
	logic signed [65:0]          prod;
	logic signed [45:0]          diff;
	logic signed [30:0]          press_full;

	// Stage 5: OFF2 = 2.5 A (+ 7 B) and SENS2 = 1.25 A (+ 5.5 B).
	assign ext_a    = {6'b0, s4.a};
	assign ext_b    = {5'b0, s4.b};
	assign five_a   = ext_a + (ext_a << 2);
	assign seven_b  = (ext_b << 3) - ext_b;
	assign eleven_b = (ext_b << 3) + (ext_b << 1) + ext_b;

	always_comb begin
		off2_c  = '0;
		sens2_c = '0;
		if (s4.lt2000) begin
			off2_c  = five_a >> 1;
			sens2_c = five_a >> 2;
			if (s4.lt1500) begin
				off2_c  = (five_a >> 1) + seven_b;
				sens2_c = (five_a >> 2) + (eleven_b >> 1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[5]) begin
			d1_s5    <= s4.d1;
			temp_s5  <= s4.temp;
			off1_s5  <= s4.off1;
			sens1_s5 <= s4.sens1;
			off2_s5  <= off2_c;
			sens2_s5 <= sens2_c;
		end
	end

	// Stage 6: final OFF and SENS.
	always_ff @(posedge clk) begin
		if (en[6]) begin
			d1_s6   <= d1_s5;
			temp_s6 <= temp_s5;
			off_s6  <= off1_s5 - $signed(off2_s5);
			sens_s6 <= sens1_s5 - $signed(sens2_s5);
		end
	end

	// Stage 7: D1 * SENS as two partial products over the low and high halves.
	always_ff @(posedge clk) begin
		if (en[7]) begin
			temp_s7  <= temp_s6;
			off_s7   <= off_s6;
			pp_lo_s7 <= d1_s6 * sens_s6[19:0];
			pp_hi_s7 <= $signed({1'b0, d1_s6}) * $signed(sens_s6[40:20]);
		end
	end

	// Stage 8: recombine the product and divide by 2^21.
	assign prod = $signed({pp_hi_s7, 20'b0}) + $signed({22'b0, pp_lo_s7});

	always_ff @(posedge clk) begin
		if (en[8]) begin
			temp_s8 <= temp_s7;
			off_s8  <= off_s7;
			q_s8    <= prod[65:21];
		end
	end

	// Stage 9: subtract OFF, divide by 2^15 and saturate both results.
	assign diff       = $signed({q_s8[44], q_s8}) - $signed({{5{off_s8[40]}}, off_s8});
	assign press_full = diff[45:15];

	always_ff @(posedge clk) begin
		if (en[9]) begin
			if (press_full[30]) begin
				pressure_s9 <= '0;
			end else if (press_full[29:20] != '0) begin
				pressure_s9 <= bpt_pkg::PRESS_MAX;
			end else begin
				pressure_s9 <= press_full[bpt_pkg::PRESS_W-1:0];
			end
			if (temp_s8[20] && (temp_s8[19:15] != 5'h1F)) begin
				temperature_s9 <= bpt_pkg::TEMP_MIN;
			end else if (!temp_s8[20] && (temp_s8[19:15] != 5'h00)) begin
				temperature_s9 <= bpt_pkg::TEMP_MAX;
			end else begin
				temperature_s9 <= temp_s8[bpt_pkg::TOUT_W-1:0];
			end
		end
	end

	assign pressure_pa       = pressure_s9;
	assign temperature_centi = temperature_s9;

endmodule

/* design/baro_pressure_temp_compensation.sv */
// Top level: second-order compensated barometric pressure and temperature.
// An accepted item moves through the stage registers in order; m_tvalid is the valid bit of the last stage.
// Throughput: one item per cycle while the output is not stalled, set by the nine-stage pipeline with one register per stage.
// A stalled output holds the pipeline; bubbles are filled so input is taken until all stages are full.
// Reset (arst_n low) clears all valid bits and sets the six calibration words to zero.
module baro_pressure_temp_compensation (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bpt_pkg::IDX_W-1:0]     cfg_index,
	input  logic [bpt_pkg::CAL_W-1:0]     cfg_data,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [47:0]                   s_tdata,   // raw_pressure, raw_temperature
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [39:0]                   m_tdata    // pressure_pa, temperature_centi, zero pad
);

	bpt_pkg::bpt_cal_t                  cal;
	bpt_pkg::bpt_s4_t                   s4;
	logic [bpt_pkg::NUM_STAGES:1]       en;
	logic [bpt_pkg::PRESS_W-1:0]        pressure_pa;
	logic signed [bpt_pkg::TOUT_W-1:0]  temperature_centi;

	// Calibration words.
	bpt_cal_regs u_cal (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cal       (cal)
	);

	// Flow control of the pipeline.
	bpt_pipe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.out_ready (m_tready),
		.en        (en),
		.out_valid (m_tvalid)
	);

	// Temperature and first-order stages.
	bpt_temp_stages u_temp (
		.clk             (clk),
		.en              (en[4:1]),
		.cal             (cal),
		.raw_pressure    (s_tdata[23:0]),
		.raw_temperature (s_tdata[47:24]),
		.s4              (s4)
	);

	// Second-order and pressure stages.
	bpt_press_stages u_press (
		.clk               (clk),
		.en                (en[9:5]),
		.s4                (s4),
		.pressure_pa       (pressure_pa),
		.temperature_centi (temperature_centi)
	);

	assign s_tready = en[1];
	assign m_tdata  = {4'b0, temperature_centi, pressure_pa};

endmodule

/* tb/tb_baro_pressure_temp_compensation.sv */
// Self-checking testbench for the barometric pressure and temperature compensation pipeline.
module tb_baro_pressure_temp_compensation;
	timeunit 1ns;
	timeprecision 1ps;

	// Register indexes past the six calibration words; writes to them must be dropped.
	localparam logic [bpt_pkg::IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [bpt_pkg::IDX_W-1:0] REG_SPARE_HI = 3'd7;

	localparam int NUM_DIRECTED = 18;
	localparam int NUM_PHASES = 10;
	localparam int ITEMS_PER_PHASE = 95;
	localparam logic [bpt_pkg::D_W-1:0] D_MAX = 24'hFFFFFF;

	// Calibration sets used by the directed items.
	localparam bpt_pkg::bpt_cal_t CAL_ZERO = '0;
	localparam bpt_pkg::bpt_cal_t CAL_PRESS_HIGH = '{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000};
	localparam bpt_pkg::bpt_cal_t CAL_OFFSET_ONLY = '{16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000};
	localparam bpt_pkg::bpt_cal_t CAL_TEMP_HIGH = '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF};
	localparam bpt_pkg::bpt_cal_t CAL_TEMP_LOW = '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF};
	localparam bpt_pkg::bpt_cal_t CAL_NOMINAL = '{16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312};
	// C5 and C6 chosen so that TEMP = 2000 + (D2 - 8388608) / 256.
	localparam bpt_pkg::bpt_cal_t CAL_STEP_TEMP = '{16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd32768, 16'd32768};

	typedef struct packed {
		logic [bpt_pkg::PRESS_W-1:0]       pressure;
		logic signed [bpt_pkg::TOUT_W-1:0] temperature;
	} reading_t;

	typedef struct {
		bpt_pkg::bpt_cal_t       cal;
		logic [bpt_pkg::D_W-1:0] d1;
		logic [bpt_pkg::D_W-1:0] d2;
		bit                      known;
		reading_t                want;
	} stim_row_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         cfg_we = 1'b0;
	logic [bpt_pkg::IDX_W-1:0]    cfg_index = '0;
	logic [bpt_pkg::CAL_W-1:0]    cfg_data = '0;
	logic                         s_tvalid = 1'b0;
	logic                         s_tready;
	logic [47:0]                  s_tdata = '0;
	logic                         m_tvalid;
	logic                         m_tready = 1'b0;
	logic [39:0]                  m_tdata;

	bpt_pkg::bpt_cal_t  cal_words = '0;
	reading_t           pending_readings [$];
	stim_row_t          dir_rows [NUM_DIRECTED];
	int                 errors = 0;
	int                 send_idle_pct = 0;
	int                 sink_stall_pct = 0;

	baro_pressure_temp_compensation dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #2 clk = ~clk;

	// Integer second-order compensation of one raw conversion pair.
	function automatic reading_t compensate(input bpt_pkg::bpt_cal_t c,
			input logic [bpt_pkg::D_W-1:0] d1_raw, input logic [bpt_pkg::D_W-1:0] d2_raw);
		longint dt, temp, off, sens, t2, off2, sens2, a, b, press, d1;
		reading_t r;
		d1 = longint'({40'd0, d1_raw});
		dt = longint'({40'd0, d2_raw}) - longint'({48'd0, c.c5}) * 256;
		temp = 2000 + ((dt * longint'({48'd0, c.c6})) >>> 23);
		off = longint'({48'd0, c.c2}) * 65536 + ((longint'({48'd0, c.c4}) * dt) >>> 7);
		sens = longint'({48'd0, c.c1}) * 32768 + ((longint'({48'd0, c.c3}) * dt) >>> 8);
		t2 = 0;
		off2 = 0;
		sens2 = 0;
		// Second-order correction, tested on the first-order temperature.
		if (temp < 2000) begin
			a = (temp - 2000) * (temp - 2000);
			t2 = (dt * dt) >>> 31;
			off2 = (5 * a) >>> 1;
			sens2 = (5 * a) >>> 2;
			if (temp < -1500) begin
				b = (temp + 1500) * (temp + 1500);
				off2 = off2 + 7 * b;
				sens2 = sens2 + ((11 * b) >>> 1);
			end
		end
		temp = temp - t2;
		off = off - off2;
		sens = sens - sens2;
		press = (((d1 * sens) >>> 21) - off) >>> 15;
		// Saturate both results to their output ranges.
		if (press < 0)
			press = 0;
		if (press > 1048575)
			press = 1048575;
		if (temp < -32768)
			temp = -32768;
		if (temp > 32767)
			temp = 32767;
		r.pressure = press[bpt_pkg::PRESS_W-1:0];
		r.temperature = temp[bpt_pkg::TOUT_W-1:0];
		return r;
	endfunction

	task automatic select_idling(input int mode);
		case (mode % 4)
			0: begin
				send_idle_pct = 0;
				sink_stall_pct = 0;
			end
			1: begin
				send_idle_pct = 69;
				sink_stall_pct = 0;
			end
			2: begin
				send_idle_pct = 0;
				sink_stall_pct = 69;
			end
			default: begin
				send_idle_pct = 17;
				sink_stall_pct = 17;
			end
		endcase
	endtask

	// Drives one register write; the caller lowers the write enable after the last one.
	task automatic write_reg(input logic [bpt_pkg::IDX_W-1:0] idx,
			input logic [bpt_pkg::CAL_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	// Waits until the pipeline is empty, then loads a new calibration set.
	task automatic recalibrate(input bpt_pkg::bpt_cal_t c);
		s_tvalid <= 1'b0;
		while (pending_readings.size() != 0)
			@(posedge clk);
		write_reg(REG_SPARE_LO, bpt_pkg::CAL_W'($urandom));
		write_reg(REG_SPARE_HI, bpt_pkg::CAL_W'($urandom));
		write_reg(bpt_pkg::REG_C1, c.c1);
		write_reg(bpt_pkg::REG_C2, c.c2);
		write_reg(bpt_pkg::REG_C3, c.c3);
		write_reg(bpt_pkg::REG_C4, c.c4);
		write_reg(bpt_pkg::REG_C5, c.c5);
		write_reg(bpt_pkg::REG_C6, c.c6);
		cfg_we <= 1'b0;
		cal_words = c;
	endtask

	// Offers one item and records its expected reading once it is taken.
	task automatic send_conversion(input logic [bpt_pkg::D_W-1:0] d1,
			input logic [bpt_pkg::D_W-1:0] d2, input bit known, input reading_t typed);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {d2, d1};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pending_readings.push_back(known ? typed : compensate(cal_words, d1, d2));
	endtask

	// Receiver: random back-pressure and comparison with the oldest expected reading.
	always @(posedge clk) begin : sink
		reading_t got;
		reading_t want;
		m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
		if (m_tvalid && m_tready) begin
			got.pressure = m_tdata[bpt_pkg::PRESS_W-1:0];
			got.temperature = m_tdata[bpt_pkg::PRESS_W +: bpt_pkg::TOUT_W];
			if (pending_readings.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected reading: pressure %0d temperature %0d",
						got.pressure, got.temperature);
			end else begin
				want = pending_readings.pop_front();
				if (got !== want) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: pressure exp %0d got %0d, temperature exp %0d got %0d",
							want.pressure, got.pressure, want.temperature, got.temperature);
				end
			end
		end
	end

	// Hard limit on the run time.
	initial begin
		#2000000;
		$display("status: fail");
		$finish;
	end

	initial begin : stimulus
		int i;
		int k;
		bpt_pkg::bpt_cal_t c;
		logic [bpt_pkg::D_W-1:0] d1;
		logic [bpt_pkg::D_W-1:0] d2;
		longint span;
		longint target;

		// Directed items: reset state, saturation corners and the temperature thresholds.
		dir_rows[0] = '{CAL_ZERO, 24'h000000, 24'h000000, 1'b1, '{20'd0, 16'sd2000}};
		dir_rows[1] = '{CAL_ZERO, D_MAX, D_MAX, 1'b1, '{20'd0, 16'sd2000}};
		dir_rows[2] = '{CAL_ZERO, 24'hAAAAAA, 24'h555555, 1'b1, '{20'd0, 16'sd2000}};
		dir_rows[3] = '{CAL_ZERO, 24'h555555, 24'hAAAAAA, 1'b1, '{20'd0, 16'sd2000}};
		dir_rows[4] = '{CAL_PRESS_HIGH, D_MAX, D_MAX, 1'b1, '{bpt_pkg::PRESS_MAX, 16'sd2000}};
		dir_rows[5] = '{CAL_PRESS_HIGH, 24'h000000, D_MAX, 1'b1, '{20'd0, 16'sd2000}};
		dir_rows[6] = '{CAL_OFFSET_ONLY, D_MAX, 24'h000000, 1'b1, '{20'd0, 16'sd2000}};
		dir_rows[7] = '{CAL_TEMP_HIGH, D_MAX, D_MAX, 1'b1, '{20'd0, bpt_pkg::TEMP_MAX}};
		dir_rows[8] = '{CAL_TEMP_LOW, 24'h000000, 24'h000000, 1'b1,
			'{bpt_pkg::PRESS_MAX, bpt_pkg::TEMP_MIN}};
		dir_rows[9] = '{CAL_TEMP_LOW, D_MAX, 24'h000000, 1'b0, '0};
		dir_rows[10] = '{CAL_NOMINAL, 24'd9085466, 24'd8569150, 1'b0, '0};
		dir_rows[11] = '{CAL_NOMINAL, 24'h000000, 24'h000000, 1'b0, '0};
		dir_rows[12] = '{CAL_NOMINAL, D_MAX, D_MAX, 1'b0, '0};
		dir_rows[13] = '{CAL_STEP_TEMP, 24'd9085466, 24'd8388608, 1'b0, '0};
		dir_rows[14] = '{CAL_STEP_TEMP, 24'd9085466, 24'd8388352, 1'b0, '0};
		dir_rows[15] = '{CAL_STEP_TEMP, 24'd9085466, 24'd7492608, 1'b0, '0};
		dir_rows[16] = '{CAL_STEP_TEMP, 24'd9085466, 24'd7492352, 1'b0, '0};
		dir_rows[17] = '{CAL_STEP_TEMP, D_MAX, 24'h000000, 1'b0, '0};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < NUM_DIRECTED; i++) begin
			select_idling(i / 4);
			if (dir_rows[i].cal != cal_words)
				recalibrate(dir_rows[i].cal);
			send_conversion(dir_rows[i].d1, dir_rows[i].d2, dir_rows[i].known, dir_rows[i].want);
		end

		// Random phases, each with a calibration set and one of four idling patterns.
		for (int p = 0; p < NUM_PHASES; p++) begin
			select_idling(p);
			case (p)
				0: c = '1;
				1: c = CAL_NOMINAL;
				default: begin
					for (k = 0; k < 6; k++) begin
						case ($urandom_range(0, 7))
							0: c[k*bpt_pkg::CAL_W +: bpt_pkg::CAL_W] = '0;
							1: c[k*bpt_pkg::CAL_W +: bpt_pkg::CAL_W] = '1;
							default: c[k*bpt_pkg::CAL_W +: bpt_pkg::CAL_W] =
								bpt_pkg::CAL_W'($urandom);
						endcase
					end
				end
			endcase
			recalibrate(c);
			for (i = 0; i < ITEMS_PER_PHASE; i++) begin
				case ($urandom_range(0, 7))
					0: d1 = '0;
					1: d1 = D_MAX;
					default: d1 = bpt_pkg::D_W'($urandom);
				endcase
				// Half the items land near the reference temperature to reach the corrections.
				if ($urandom_range(0, 1) == 0) begin
					span = longint'(1) << $urandom_range(0, 24);
					target = longint'({48'd0, cal_words.c5}) * 256
						+ longint'($urandom_range(0, 2 * span)) - span;
					if (target < 0)
						target = 0;
					if (target > 16777215)
						target = 16777215;
					d2 = target[bpt_pkg::D_W-1:0];
				end else begin
					case ($urandom_range(0, 7))
						0: d2 = '0;
						1: d2 = D_MAX;
						default: d2 = bpt_pkg::D_W'($urandom);
					endcase
				end
				send_conversion(d1, d2, 1'b0, '0);
			end
		end

		// Drain, then keep the receiver running for any stray reading before the verdict.
		s_tvalid <= 1'b0;
		while (pending_readings.size() != 0)
			@(posedge clk);
		repeat (bpt_pkg::NUM_STAGES + 4) @(posedge clk);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

/* sim.f */
design/bpt_pkg.sv
design/bpt_cal_regs.sv
design/bpt_pipe_ctrl.sv
design/bpt_temp_stages.sv
design/bpt_press_stages.sv
design/baro_pressure_temp_compensation.sv
tb/tb_baro_pressure_temp_compensation.sv
